[rtl/core/rclce_pkg.sv]
// rclce_pkg: shared types, codes and fixed-point helpers of the RC link chain
// delay evaluator. No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package rclce_pkg;

	localparam int DATA_W        = 32;
	localparam int MAX_LINKS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	typedef logic signed [DATA_W-1:0] q_t;

	// item operation codes
	typedef enum logic [1:0] {
		OP_FIRST  = 2'd0,
		OP_MIDDLE = 2'd1,
		OP_FINAL  = 2'd2,
		OP_EVAL   = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CONF_BASE = 3'd0,
		REG_CONF_GAIN = 3'd1,
		REG_RES       = 3'd2,
		REG_SLEW_GAIN = 3'd3,
		REG_FIXED     = 3'd4,
		REG_MID_COUNT = 3'd5,
		REG_FINAL     = 3'd6
	} reg_idx_t;

	// shared unit modes: Q multiply with floor shift, or product over divisor
	typedef enum logic {
		MD_MUL = 1'b0,
		MD_DIV = 1'b1
	} md_mode_t;

	// one link record
	typedef struct packed {
		q_t   acti;
		q_t   bcti;
		q_t   cap;
		q_t   k3;
		q_t   k4;
		q_t   k5;
		logic flag;
	} link_row_t;

	// one evaluate result
	typedef struct packed {
		q_t   delay;
		q_t   slew;
		logic conf;
		logic fault;
	} eval_res_t;

	function automatic q_t sat32(input logic signed [63:0] v);
		q_t r;
		if (v > 64'sd2147483647)
			r = 32'sh7fff_ffff;
		else if (v < -64'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic q_t qadd(input q_t a, input q_t b);
		logic signed [63:0] s;
		s = 64'(a) + 64'(b);
		return sat32(s);
	endfunction

endpackage

[rtl/core/rc_link_chain_delay_eval.sv]
// rc_link_chain_delay_eval: top level. Configuration registers, link record
// store, evaluate sequencer and shared multiply / divide unit.
// Depends on rclce_pkg, rclce_store, rclce_seq, rclce_mdu.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Record writes
// (operations 0 to 2) leave busy low. An evaluate raises busy until its
// result appears on result_valid for exactly one cycle; the result cannot
// be held off and must be captured then. Every product and quotient goes
// through one shared unit: a multiply step is a product and a floor shift,
// a divide step a product and a restoring divide (one quotient bit per
// cycle), so an evaluate grows with the square of the middle links in use.
// Configuration writes are always accepted (cfg_ready is tied high)
// and belong in idle periods.

module rc_link_chain_delay_eval #(
	parameter int MAX_LINKS = rclce_pkg::MAX_LINKS_DEF,
	parameter int FRAC_BITS = rclce_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [3:0]  link_index,
	input  logic [31:0] link_acti,
	input  logic [31:0] link_bcti,
	input  logic [31:0] link_cap,
	input  logic        link_conflict,
	input  logic [31:0] link_k3,
	input  logic [31:0] link_k4,
	input  logic [31:0] link_k5,
	input  logic [31:0] load_cap,
	input  logic [31:0] input_slew,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output logic [31:0] delay,
	output logic [31:0] output_slew,
	output logic        conflict_added,
	output logic        divide_fault
);
	import rclce_pkg::*;

	localparam int IDX_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

	q_t         conf_base_q, conf_gain_q, res_tot_q, slew_gain_q, fixed_q;
	logic [4:0] mid_count_q;
	logic       final_on_q;

	logic               accept;
	logic               eval_go;
	link_row_t          wr_row, rd_row, first_row, final_row;
	logic [IDX_W-1:0]   rd_addr;
	eval_res_t          res;
	logic               md_go, md_done;
	md_mode_t           md_mode;
	q_t                 md_a, md_b, md_res;
	logic signed [63:0] md_div;

	assign accept  = start && !busy;
	assign eval_go = accept && (op_t'(operation) == OP_EVAL);

	// configuration register file
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_base_q <= '0;
			conf_gain_q <= '0;
			res_tot_q   <= '0;
			slew_gain_q <= '0;
			fixed_q     <= '0;
			mid_count_q <= '0;
			final_on_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CONF_BASE: conf_base_q <= cfg_data;
				REG_CONF_GAIN: conf_gain_q <= cfg_data;
				REG_RES:       res_tot_q   <= cfg_data;
				REG_SLEW_GAIN: slew_gain_q <= cfg_data;
				REG_FIXED:     fixed_q     <= cfg_data;
				REG_MID_COUNT: mid_count_q <= cfg_data[4:0];
				REG_FINAL:     final_on_q  <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// record beat as written to the store
	always_comb begin
		wr_row.acti = link_acti;
		wr_row.bcti = link_bcti;
		wr_row.cap  = link_cap;
		wr_row.k3   = link_k3;
		wr_row.k4   = link_k4;
		wr_row.k5   = link_k5;
		wr_row.flag = link_conflict;
	end

	rclce_store #(
		.MAX_LINKS (MAX_LINKS)
	) u_store (
		.clk       (clk),
		.wr_en     (accept),
		.op        (op_t'(operation)),
		.slot      (link_index),
		.wr_row    (wr_row),
		.rd_addr   (rd_addr),
		.rd_row    (rd_row),
		.first_row (first_row),
		.final_row (final_row)
	);

	rclce_seq #(
		.MAX_LINKS (MAX_LINKS),
		.FRAC_BITS (FRAC_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (eval_go),
		.load      (load_cap),
		.slew      (input_slew),
		.conf_base (conf_base_q),
		.conf_gain (conf_gain_q),
		.res_tot   (res_tot_q),
		.slew_gain (slew_gain_q),
		.fixed_dly (fixed_q),
		.mid_count (mid_count_q),
		.final_on  (final_on_q),
		.first_row (first_row),
		.final_row (final_row),
		.rd_row    (rd_row),
		.rd_addr   (rd_addr),
		.busy      (busy),
		.res_valid (result_valid),
		.res       (res),
		.md_go     (md_go),
		.md_mode   (md_mode),
		.md_a      (md_a),
		.md_b      (md_b),
		.md_div    (md_div),
		.md_done   (md_done),
		.md_res    (md_res)
	);

	rclce_mdu #(
		.FRAC_BITS (FRAC_BITS)
	) u_mdu (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (md_go),
		.mode    (md_mode),
		.a       (md_a),
		.b       (md_b),
		.divisor (md_div),
		.done    (md_done),
		.res     (md_res)
	);

	assign delay          = res.delay;
	assign output_slew    = res.slew;
	assign conflict_added = res.conf;
	assign divide_fault   = res.fault;

	// an evaluate holds the block until its result
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_EVAL) |=> busy)
		else $error("evaluate accepted without going busy");

	// results only close out a busy period
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(busy) && !busy))
		else $error("result strobe outside an evaluate");

	// record writes never yield a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation != OP_EVAL) |=> !result_valid)
		else $error("result after a record write");

endmodule

[rtl/core/rclce_mdu.sv]
// rclce_mdu: shared multiply / divide unit. One signed 32x32 product, then
// either a floor shift by the fraction bits or a restoring divide, saturated.
// Depends on rclce_pkg.
`timescale 1ns / 1ps

module rclce_mdu #(
	parameter int FRAC_BITS = rclce_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  rclce_pkg::md_mode_t mode,
	input  rclce_pkg::q_t       a,
	input  rclce_pkg::q_t       b,
	input  logic signed [63:0]  divisor,
	output logic                done,
	output rclce_pkg::q_t       res
);
	import rclce_pkg::*;

	typedef enum logic [1:0] {U_IDLE, U_PROD, U_DIV, U_FIN} ustate_t;

	ustate_t            st_q;
	md_mode_t           mode_q;
	logic signed [63:0] prod_q;
	logic [63:0]        dvs_q;
	logic [63:0]        acc_q;
	logic [63:0]        rem_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	logic               done_q;
	q_t                 res_q;

	logic [64:0]        rem_sh;
	logic [65:0]        diff;
	logic signed [63:0] quot;

	// one restoring step per cycle
	always_comb begin
		rem_sh = {rem_q, acc_q[63]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		quot   = neg_q ? -$signed(acc_q) : $signed(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			mode_q <= MD_MUL;
			prod_q <= '0;
			dvs_q  <= '0;
			acc_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			done_q <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				U_IDLE: begin
					if (go) begin
						prod_q <= a * b;
						mode_q <= mode;
						dvs_q  <= divisor;
						st_q   <= U_PROD;
					end
				end
				U_PROD: begin
					if (mode_q == MD_MUL) begin
						res_q  <= sat32(prod_q >>> FRAC_BITS);
						done_q <= 1'b1;
						st_q   <= U_IDLE;
					end else begin
						acc_q <= prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
						dvs_q <= dvs_q[63] ? (~dvs_q + 64'd1) : dvs_q;
						neg_q <= prod_q[63] ^ dvs_q[63];
						rem_q <= '0;
						cnt_q <= '0;
						st_q  <= U_DIV;
					end
				end
				U_DIV: begin
					if (!diff[65]) begin
						rem_q <= diff[63:0];
						acc_q <= {acc_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh[63:0];
						acc_q <= {acc_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						st_q <= U_FIN;
				end
				U_FIN: begin
					res_q  <= sat32(quot);
					done_q <= 1'b1;
					st_q   <= U_IDLE;
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/core/rclce_store.sv]
// rclce_store: link record storage. First and final records in registers,
// middle records in a one-write, one-read memory with registered read.
// Depends on rclce_pkg.
`timescale 1ns / 1ps

module rclce_store #(
	parameter int MAX_LINKS = rclce_pkg::MAX_LINKS_DEF,
	localparam int IDX_W    = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  rclce_pkg::op_t       op,
	input  logic [3:0]           slot,
	input  rclce_pkg::link_row_t wr_row,
	input  logic [IDX_W-1:0]     rd_addr,
	output rclce_pkg::link_row_t rd_row,
	output rclce_pkg::link_row_t first_row,
	output rclce_pkg::link_row_t final_row
);
	import rclce_pkg::*;

	link_row_t mem [MAX_LINKS];
	link_row_t rd_q;
	link_row_t first_q;
	link_row_t final_q;

	// record writes; slots past the array are dropped
	always_ff @(posedge clk) begin
		if (wr_en) begin
			unique case (op)
				OP_FIRST:  first_q <= wr_row;
				OP_MIDDLE: begin
					if (32'(slot) < MAX_LINKS)
						mem[IDX_W'(slot)] <= wr_row;
				end
				OP_FINAL:  final_q <= wr_row;
				OP_EVAL:   ;
				default:   ;
			endcase
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rd_row    = rd_q;
	assign first_row = first_q;
	assign final_row = final_q;

endmodule

[rtl/core/rclce_seq.sv]
// rclce_seq: evaluate sequencer. Walks the chain fold, the driver RC term and
// the prefix slope terms, issuing every product and quotient to rclce_mdu.
// Depends on rclce_pkg.
`timescale 1ns / 1ps

module rclce_seq #(
	parameter int MAX_LINKS = rclce_pkg::MAX_LINKS_DEF,
	parameter int FRAC_BITS = rclce_pkg::FRAC_BITS_DEF,
	localparam int IDX_W    = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  rclce_pkg::q_t        load,
	input  rclce_pkg::q_t        slew,
	input  rclce_pkg::q_t        conf_base,
	input  rclce_pkg::q_t        conf_gain,
	input  rclce_pkg::q_t        res_tot,
	input  rclce_pkg::q_t        slew_gain,
	input  rclce_pkg::q_t        fixed_dly,
	input  logic [4:0]           mid_count,
	input  logic                 final_on,
	input  rclce_pkg::link_row_t first_row,
	input  rclce_pkg::link_row_t final_row,
	input  rclce_pkg::link_row_t rd_row,
	output logic [IDX_W-1:0]     rd_addr,
	output logic                 busy,
	output logic                 res_valid,
	output rclce_pkg::eval_res_t res,
	output logic                 md_go,
	output rclce_pkg::md_mode_t  md_mode,
	output rclce_pkg::q_t        md_a,
	output rclce_pkg::q_t        md_b,
	output logic signed [63:0]   md_div,
	input  logic                 md_done,
	input  rclce_pkg::q_t        md_res
);
	import rclce_pkg::*;

	localparam int I_W = $clog2(MAX_LINKS + 2);
	localparam logic signed [41:0] ONE_K  = 42'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] RC_DIV = 64'sd1000 <<< FRAC_BITS;

	typedef enum logic [4:0] {
		S_IDLE, S_C0, S_CONF, S_FOLD_CHK, S_RD_A, S_RD_B, S_FOLD_NUM, S_FOLD_DEN,
		S_FOLD_END, S_TP_RC, S_TP_SG, S_SL_CHK, S_PF_CHK, S_PF_NUM, S_PF_DIV,
		S_SL_DIV, S_SL_X, S_SL_D, S_SL_V, S_SL_F, S_FS, S_DONE
	} state_t;

	state_t             st_q, nxt_q;
	logic               pend_q;
	logic               md_go_q;
	md_mode_t           md_mode_q;
	q_t                 md_a_q, md_b_q;
	logic signed [63:0] md_div_q;
	logic [IDX_W-1:0]   addr_q;
	logic [I_W-1:0]     i_q, n_q, cnt_q;
	logic               last_q;
	q_t                 load_q, slew_q;
	q_t                 capa_q, num_q, den_q, front_q, val_q, tp_q, rc_q, x_q;
	logic               conf_q, fault_q;
	link_row_t          lnk_q;
	eval_res_t          res_q;
	logic               res_valid_q;

	logic signed [41:0] den_k;
	logic               den_small;
	q_t                 num_w;

	// fold denominator test against 0.001, and numerator from the unit result
	always_comb begin
		den_k     = 42'(den_q) * 42'sd1000;
		den_small = den_k < ONE_K;
		num_w     = qadd(lnk_q.acti, md_res);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			nxt_q       <= S_IDLE;
			pend_q      <= 1'b0;
			md_go_q     <= 1'b0;
			md_mode_q   <= MD_MUL;
			md_a_q      <= '0;
			md_b_q      <= '0;
			md_div_q    <= '0;
			addr_q      <= '0;
			i_q         <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			load_q      <= '0;
			slew_q      <= '0;
			capa_q      <= '0;
			num_q       <= '0;
			den_q       <= '0;
			front_q     <= '0;
			val_q       <= '0;
			tp_q        <= '0;
			rc_q        <= '0;
			x_q         <= '0;
			conf_q      <= 1'b0;
			fault_q     <= 1'b0;
			lnk_q       <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			md_go_q     <= 1'b0;
			res_valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (go) begin
						load_q  <= load;
						slew_q  <= slew;
						conf_q  <= 1'b0;
						fault_q <= 1'b0;
						pend_q  <= 1'b0;
						cnt_q   <= (32'(mid_count) > MAX_LINKS) ? I_W'(MAX_LINKS)
						                                       : I_W'(mid_count);
						st_q    <= S_C0;
					end
				end
				// chain fold starts from the first link
				S_C0: begin
					capa_q <= qadd(first_row.cap, load_q);
					i_q    <= '0;
					if (first_row.flag) begin
						conf_q <= 1'b1;
						st_q   <= S_CONF;
					end else begin
						st_q <= S_FOLD_CHK;
					end
				end
				S_CONF: begin
					if (!pend_q) begin
						md_go_q <= 1'b1; md_mode_q <= MD_MUL;
						md_a_q <= conf_gain; md_b_q <= slew_q; md_div_q <= '0;
						pend_q <= 1'b1;
					end else if (md_done) begin
						pend_q <= 1'b0;
						capa_q <= qadd(capa_q, qadd(conf_base, md_res));
						st_q   <= S_FOLD_CHK;
					end
				end
				S_FOLD_CHK: begin
					if (i_q < cnt_q) begin
						addr_q <= IDX_W'(i_q);
						nxt_q  <= S_FOLD_NUM;
						st_q   <= S_RD_A;
					end else if (i_q == cnt_q && final_on) begin
						lnk_q <= final_row;
						st_q  <= S_FOLD_NUM;
					end else begin
						st_q <= S_TP_RC;
					end
				end
				// memory read: address settles, then data arrives
				S_RD_A: st_q <= S_RD_B;
				S_RD_B: begin
					lnk_q <= rd_row;
					st_q  <= nxt_q;
				end
				S_FOLD_NUM: begin
					if (!pend_q) begin
						md_go_q <= 1'b1; md_mode_q <= MD_MUL;
						md_a_q <= lnk_q.bcti; md_b_q <= load_q; md_div_q <= '0;
						pend_q <= 1'b1;
					end else if (md_done) begin
						pend_q <= 1'b0;
						num_q  <= num_w;
						den_q  <= qadd(num_w, capa_q);
						st_q   <= S_FOLD_DEN;
					end
				end
				S_FOLD_DEN: begin
					if (!pend_q) begin
						if (den_small) begin
							capa_q <= '0;
							st_q   <= S_FOLD_END;
						end else begin
							md_go_q <= 1'b1; md_mode_q <= MD_DIV;
							md_a_q <= num_q; md_b_q <= capa_q; md_div_q <= 64'(den_q);
							pend_q <= 1'b1;
						end
					end else if (md_done) begin
						pend_q <= 1'b0;
						capa_q <= qadd(lnk_q.cap, md_res);
						st_q   <= S_FOLD_END;
					end
				end
				S_FOLD_END: begin
					i_q <= i_q + I_W'(1);
					if (lnk_q.flag && !conf_q) begin
						conf_q <= 1'b1;
						st_q   <= S_CONF;
					end else begin
						st_q <= S_FOLD_CHK;
					end
				end
				// driver RC term and slew part of the delay
				S_TP_RC: begin
					if (!pend_q) begin
						md_go_q <= 1'b1; md_mode_q <= MD_DIV;
						md_a_q <= res_tot; md_b_q <= capa_q; md_div_q <= RC_DIV;
						pend_q <= 1'b1;
					end else if (md_done) begin
						pend_q <= 1'b0;
						rc_q   <= md_res;
						st_q   <= S_TP_SG;
					end
				end
				S_TP_SG: begin
					if (!pend_q) begin
						md_go_q <= 1'b1; md_mode_q <= MD_MUL;
						md_a_q <= slew_gain; md_b_q <= slew_q; md_div_q <= '0;
						pend_q <= 1'b1;
					end else if (md_done) begin
						pend_q  <= 1'b0;
						tp_q    <= qadd(rc_q, md_res);
						front_q <= qadd(slew_q, rc_q);
						val_q   <= '0;
						i_q     <= cnt_q;
						last_q  <= 1'b0;
						st_q    <= S_SL_CHK;
					end
				end
				// prefixes, longest first
				S_SL_CHK: begin
					if (i_q != '0) begin
						capa_q <= qadd(first_row.cap, load_q);
						n_q    <= '0;
						st_q   <= S_PF_CHK;
					end else begin
						st_q <= S_FS;
					end
				end
				S_PF_CHK: begin
					if (n_q < i_q) begin
						addr_q <= IDX_W'(n_q);
						nxt_q  <= S_PF_NUM;
					end else begin
						addr_q <= IDX_W'(i_q - I_W'(1));
						nxt_q  <= S_SL_DIV;
					end
					st_q <= S_RD_A;
				end
				S_PF_NUM: begin
					if (!pend_q) begin
						md_go_q <= 1'b1; md_mode_q <= MD_MUL;
						md_a_q <= lnk_q.bcti; md_b_q <= load_q; md_div_q <= '0;
						pend_q <= 1'b1;
					end else if (md_done) begin
						pend_q <= 1'b0;
						num_q  <= num_w;
						den_q  <= qadd(num_w, capa_q);
						st_q   <= S_PF_DIV;
					end
				end
				S_PF_DIV: begin
					if (!pend_q) begin
						if (den_q == '0) begin
							fault_q <= 1'b1;
							capa_q  <= lnk_q.cap;
							n_q     <= n_q + I_W'(1);
							st_q    <= S_PF_CHK;
						end else begin
							md_go_q <= 1'b1; md_mode_q <= MD_DIV;
							md_a_q <= num_q; md_b_q <= capa_q; md_div_q <= 64'(den_q);
							pend_q <= 1'b1;
						end
					end else if (md_done) begin
						pend_q <= 1'b0;
						capa_q <= qadd(lnk_q.cap, md_res);
						n_q    <= n_q + I_W'(1);
						st_q   <= S_PF_CHK;
					end
				end
				// slope term of the link in lnk_q
				S_SL_DIV: begin
					if (!pend_q) begin
						md_go_q <= 1'b1; md_mode_q <= MD_DIV;
						md_a_q <= capa_q; md_b_q <= 32'sd1; md_div_q <= 64'sd1000;
						pend_q <= 1'b1;
					end else if (md_done) begin
						pend_q <= 1'b0;
						capa_q <= md_res;
						st_q   <= S_SL_X;
					end
				end
				S_SL_X: begin
					if (!pend_q) begin
						md_go_q <= 1'b1; md_mode_q <= MD_MUL;
						md_a_q <= lnk_q.k3; md_b_q <= capa_q; md_div_q <= '0;
						pend_q <= 1'b1;
					end else if (md_done) begin
						pend_q <= 1'b0;
						x_q    <= md_res;
						st_q   <= S_SL_D;
					end
				end
				S_SL_D: begin
					if (!pend_q) begin
						md_go_q <= 1'b1; md_mode_q <= MD_MUL;
						md_a_q <= lnk_q.k4; md_b_q <= front_q; md_div_q <= '0;
						pend_q <= 1'b1;
					end else if (md_done) begin
						pend_q <= 1'b0;
						den_q  <= qadd(x_q, md_res);
						st_q   <= S_SL_V;
					end
				end
				S_SL_V: begin
					if (!pend_q) begin
						if (den_q == '0) begin
							fault_q <= 1'b1;
							st_q    <= S_SL_F;
						end else begin
							md_go_q <= 1'b1; md_mode_q <= MD_DIV;
							md_a_q <= x_q; md_b_q <= qadd(x_q, front_q);
							md_div_q <= 64'(den_q);
							pend_q <= 1'b1;
						end
					end else if (md_done) begin
						pend_q <= 1'b0;
						val_q  <= qadd(val_q, md_res);
						st_q   <= S_SL_F;
					end
				end
				S_SL_F: begin
					if (!pend_q) begin
						md_go_q <= 1'b1; md_mode_q <= MD_MUL;
						md_a_q <= lnk_q.k5; md_b_q <= capa_q; md_div_q <= '0;
						pend_q <= 1'b1;
					end else if (md_done) begin
						pend_q  <= 1'b0;
						front_q <= qadd(front_q, md_res);
						if (last_q) begin
							st_q <= S_DONE;
						end else begin
							i_q  <= i_q - I_W'(1);
							st_q <= S_SL_CHK;
						end
					end
				end
				// first link term only with all gains positive
				S_FS: begin
					if (first_row.k3 > 0 && first_row.k4 > 0 && first_row.k5 > 0) begin
						lnk_q  <= first_row;
						capa_q <= qadd(first_row.cap, load_q);
						last_q <= 1'b1;
						st_q   <= S_SL_DIV;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					res_q.delay <= qadd(qadd(tp_q, val_q), fixed_dly);
					res_q.slew  <= front_q;
					res_q.conf  <= conf_q;
					res_q.fault <= fault_q;
					res_valid_q <= 1'b1;
					st_q        <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rd_addr   = addr_q;
	assign busy      = (st_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign md_go     = md_go_q;
	assign md_mode   = md_mode_q;
	assign md_a      = md_a_q;
	assign md_b      = md_b_q;
	assign md_div    = md_div_q;

endmodule

[dv/tb_rc_link_chain_delay_eval.sv]
// tb_rc_link_chain_delay_eval: self-checking bench for the RC link chain delay
// evaluator. Depends on rclce_pkg and the rc_link_chain_delay_eval RTL.
`timescale 1ns / 1ps

module tb_rc_link_chain_delay_eval;
	import rclce_pkg::*;

	localparam longint Q_ONE       = 64'sd65536;
	localparam longint RC_DIVISOR  = 64'sd65536000;
	localparam int     CYCLE_LIMIT = 20000000;
	localparam int     SETTLE      = 200;

	// one command beat as driven on the input ports
	typedef struct {
		op_t        op;
		logic [3:0] idx;
		q_t         acti, bcti, cap, k3, k4, k5, load, slew;
		logic       conf;
	} cmd_t;

	// delay model of the chain plus the queue of predicted evaluate results
	class chain_scoreboard;
		longint     r_cbase, r_cgain, r_res, r_sgain, r_fixed;
		int         r_count;
		bit         r_final;
		longint     f_cap, f_k3, f_k4, f_k5;
		bit         f_flag;
		longint     m_acti[16], m_bcti[16], m_cap[16], m_k3[16], m_k4[16], m_k5[16];
		bit         m_flag[16];
		longint     e_acti, e_bcti, e_cap;
		bit         e_flag;
		eval_res_t  pending_results[$];
		int         mismatches, checked, evals, faults, conflicts;

		function new();
			r_cbase = 0; r_cgain = 0; r_res = 0; r_sgain = 0; r_fixed = 0;
			r_count = 0; r_final = 0;
			mismatches = 0; checked = 0; evals = 0; faults = 0; conflicts = 0;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint q_sum(longint a, longint b);
			return clamp32(a + b);
		endfunction

		// floor shift of the product
		function longint q_prod(longint a, longint b);
			longint p;
			p = a * b;
			return clamp32(p >>> 16);
		endfunction

		function longint q_scale(longint a, longint b, longint c);
			return clamp32((a * b) / c);
		endfunction

		function longint rc_delay(longint c);
			return clamp32((r_res * c) / RC_DIVISOR);
		endfunction

		function longint conflict_cap(longint slew);
			return q_sum(r_cbase, q_prod(r_cgain, slew));
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_CONF_BASE: r_cbase = longint'(signed'(data));
				REG_CONF_GAIN: r_cgain = longint'(signed'(data));
				REG_RES:       r_res = longint'(signed'(data));
				REG_SLEW_GAIN: r_sgain = longint'(signed'(data));
				REG_FIXED:     r_fixed = longint'(signed'(data));
				REG_MID_COUNT: r_count = int'(data[4:0]);
				REG_FINAL:     r_final = data[0];
				default: ;
			endcase
		endfunction

		// record writes update the store, an evaluate queues its prediction
		function void note_item(cmd_t c);
			int        cnt, i, n, j;
			longint    load, slew, capa, num, den, front, val, tp, x, a, b, lc;
			bit        f, conf, fault;
			eval_res_t r;
			load = c.load;
			slew = c.slew;
			case (c.op)
				OP_FIRST: begin
					f_cap = c.cap; f_k3 = c.k3; f_k4 = c.k4; f_k5 = c.k5; f_flag = c.conf;
				end
				OP_MIDDLE: begin
					m_acti[c.idx] = c.acti; m_bcti[c.idx] = c.bcti; m_cap[c.idx] = c.cap;
					m_k3[c.idx] = c.k3; m_k4[c.idx] = c.k4; m_k5[c.idx] = c.k5;
					m_flag[c.idx] = c.conf;
				end
				OP_FINAL: begin
					e_acti = c.acti; e_bcti = c.bcti; e_cap = c.cap; e_flag = c.conf;
				end
				default: begin
					cnt = (r_count > 16) ? 16 : r_count;
					conf = 0;
					fault = 0;
					// fold effective capacitance along the whole chain
					capa = q_sum(f_cap, load);
					if (f_flag) begin
						capa = q_sum(capa, conflict_cap(slew));
						conf = 1;
					end
					for (i = 0; i <= cnt; i++) begin
						if (i < cnt) begin
							a = m_acti[i]; b = m_bcti[i]; lc = m_cap[i]; f = m_flag[i];
						end else begin
							if (!r_final)
								break;
							a = e_acti; b = e_bcti; lc = e_cap; f = e_flag;
						end
						num = q_sum(a, q_prod(b, load));
						den = q_sum(num, capa);
						if (den * 1000 < Q_ONE)
							capa = 0;
						else
							capa = q_sum(lc, q_scale(num, capa, den));
						if (f && !conf) begin
							capa = q_sum(capa, conflict_cap(slew));
							conf = 1;
						end
					end
					tp = q_sum(rc_delay(capa), q_prod(r_sgain, slew));
					front = q_sum(slew, rc_delay(capa));
					val = 0;
					// slope terms over middle prefixes, longest first
					for (i = cnt; i > 0; i--) begin
						capa = q_sum(f_cap, load);
						for (n = 0; n < i; n++) begin
							num = q_sum(m_acti[n], q_prod(m_bcti[n], load));
							den = q_sum(num, capa);
							if (den == 0) begin
								fault = 1;
								capa = m_cap[n];
							end else begin
								capa = q_sum(m_cap[n], q_scale(num, capa, den));
							end
						end
						j = i - 1;
						capa = capa / 1000;
						x = q_prod(m_k3[j], capa);
						den = q_sum(x, q_prod(m_k4[j], front));
						if (den == 0)
							fault = 1;
						else
							val = q_sum(val, q_scale(x, q_sum(x, front), den));
						front = q_sum(front, q_prod(m_k5[j], capa));
					end
					// first link term, only with all gains positive
					capa = q_sum(f_cap, load) / 1000;
					if (f_k3 > 0 && f_k4 > 0 && f_k5 > 0) begin
						x = q_prod(f_k3, capa);
						den = q_sum(x, q_prod(f_k4, front));
						if (den == 0)
							fault = 1;
						else
							val = q_sum(val, q_scale(x, q_sum(x, front), den));
						front = q_sum(front, q_prod(f_k5, capa));
					end
					r.delay = q_t'(q_sum(q_sum(tp, val), r_fixed));
					r.slew = q_t'(front);
					r.conf = conf;
					r.fault = fault;
					pending_results.push_back(r);
					evals++;
					faults += fault;
					conflicts += conf;
				end
			endcase
		endfunction

		function void report(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("  %s: expected %h, got %h (result %0d)", what, want, got, checked);
		endfunction

		function void check(eval_res_t got);
			eval_res_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("  unexpected result: delay %h slew %h", got.delay, got.slew);
				return;
			end
			want = pending_results.pop_front();
			if (want.delay !== got.delay) report("delay", want.delay, got.delay);
			if (want.slew !== got.slew) report("output_slew", want.slew, got.slew);
			if (want.conf !== got.conf) report("conflict_added", want.conf, got.conf);
			if (want.fault !== got.fault) report("divide_fault", want.fault, got.fault);
			checked++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [3:0]  link_index;
	logic [31:0] link_acti, link_bcti, link_cap, link_k3, link_k4, link_k5;
	logic        link_conflict;
	logic [31:0] load_cap, input_slew;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        result_valid;
	logic [31:0] delay, output_slew;
	logic        conflict_added, divide_fault;

	chain_scoreboard sb;
	int              cycles = 0;
	int              items_sent = 0;

	rc_link_chain_delay_eval u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .link_index(link_index),
		.link_acti(link_acti), .link_bcti(link_bcti), .link_cap(link_cap),
		.link_conflict(link_conflict), .link_k3(link_k3), .link_k4(link_k4),
		.link_k5(link_k5), .load_cap(load_cap), .input_slew(input_slew),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .delay(delay),
		.output_slew(output_slew), .conflict_added(conflict_added),
		.divide_fault(divide_fault)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result capture: one beat per strobe, no hold-off possible
	always @(posedge clk) begin
		eval_res_t got;
		if (arst_n && result_valid) begin
			got.delay = delay;
			got.slew = output_slew;
			got.conf = conflict_added;
			got.fault = divide_fault;
			sb.check(got);
		end
	end

	// mostly short gaps, occasionally long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Q16.16 operand: raw, extreme, capacitance-sized or a few units
	function automatic q_t rand_q();
		case ($urandom_range(0, 7))
			0: return q_t'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fff_ffff;
					1: return 32'sh8000_0000;
					2: return 32'sh0;
					default: return -32'sd1;
				endcase
			end
			2, 3: return q_t'($urandom_range(0, 32'd131072000));
			default: return q_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		endcase
	endfunction

	function automatic cmd_t rand_cmd(op_t op, logic [3:0] idx);
		cmd_t c;
		c.op = op; c.idx = idx;
		c.acti = rand_q(); c.bcti = rand_q(); c.cap = rand_q();
		c.k3 = rand_q(); c.k4 = rand_q(); c.k5 = rand_q();
		c.load = rand_q(); c.slew = rand_q();
		c.conf = ($urandom_range(0, 3) == 0);
		return c;
	endfunction

	// one command beat: optional gap, then hold start until busy is low
	task automatic send_cmd(cmd_t c);
		int g;
		g = gap_len();
		@(negedge clk);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(negedge clk);
		end
		start <= 1'b1;
		operation <= c.op;
		link_index <= c.idx;
		link_acti <= c.acti; link_bcti <= c.bcti; link_cap <= c.cap;
		link_k3 <= c.k3; link_k4 <= c.k4; link_k5 <= c.k5;
		link_conflict <= c.conf;
		load_cap <= c.load; input_slew <= c.slew;
		do @(posedge clk); while (busy);
		sb.note_item(c);
		items_sent++;
	endtask

	// stop sending and wait for every predicted result
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic cmd_t mk(op_t op, logic [3:0] idx, q_t acti, q_t bcti, q_t cap,
			q_t k3, q_t k4, q_t k5, logic conf, q_t load, q_t slew);
		cmd_t c;
		c.op = op; c.idx = idx; c.acti = acti; c.bcti = bcti; c.cap = cap;
		c.k3 = k3; c.k4 = k4; c.k5 = k5; c.conf = conf; c.load = load; c.slew = slew;
		return c;
	endfunction

	// random phase: fresh settings, records in use written, then mixed traffic
	task automatic run_phase(int n_items, bit wide);
		int cnt, used, k, evals_left;
		cmd_t c;
		drain();
		if (wide)
			cnt = ($urandom_range(0, 1) == 0) ? 16 : $urandom_range(17, 31);
		else if ($urandom_range(0, 4) == 0)
			cnt = $urandom_range(4, 8);
		else
			cnt = $urandom_range(0, 3);
		used = (cnt > 16) ? 16 : cnt;
		cfg_write(REG_CONF_BASE, rand_q());
		cfg_write(REG_CONF_GAIN, rand_q());
		cfg_write(REG_RES, rand_q());
		cfg_write(REG_SLEW_GAIN, rand_q());
		cfg_write(REG_FIXED, rand_q());
		cfg_write(REG_MID_COUNT, {27'($urandom_range(0, 32'h07ff_ffff)), 5'(cnt)});
		cfg_write(REG_FINAL, {31'($urandom_range(0, 32'h7fff_ffff)), 1'($urandom)});
		send_cmd(rand_cmd(OP_FIRST, 4'($urandom)));
		for (k = 0; k < used; k++)
			send_cmd(rand_cmd(OP_MIDDLE, 4'(k)));
		send_cmd(rand_cmd(OP_FINAL, 4'($urandom)));
		evals_left = wide ? 2 : n_items;
		for (k = 0; k < n_items; k++) begin
			if (evals_left > 0 && $urandom_range(0, 99) < 35) begin
				send_cmd(rand_cmd(OP_EVAL, 4'($urandom)));
				evals_left--;
			end else begin
				c = rand_cmd(op_t'($urandom_range(0, 2)), 4'($urandom));
				send_cmd(c);
			end
		end
	endtask

	initial begin
		int p;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_FIRST;
		link_index = '0;
		link_acti = '0; link_bcti = '0; link_cap = '0;
		link_k3 = '0; link_k4 = '0; link_k5 = '0;
		link_conflict = 1'b0;
		load_cap = '0; input_slew = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CONF_BASE;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: one middle link, final link on
		cfg_write(REG_CONF_BASE, 32'h0001_0000);
		cfg_write(REG_CONF_GAIN, 32'h0000_8000);
		cfg_write(REG_RES, 32'h0002_0000);
		cfg_write(REG_SLEW_GAIN, 32'h0000_4000);
		cfg_write(REG_FIXED, 32'h0000_1999);
		cfg_write(REG_MID_COUNT, 32'd1);
		cfg_write(REG_FINAL, 32'd1);
		// zero load and caps: first fold collapses, prefix and slope denominators
		// are zero, conflict is picked up at the middle link
		send_cmd(mk(OP_FIRST, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0));
		send_cmd(mk(OP_MIDDLE, 0, 0, 32'h10000, 0, 32'h10000, 0, 32'h10000, 1, 0, 0));
		send_cmd(mk(OP_FINAL, 4'hf, 32'h10000, 0, 32'h10000, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h10000));
		// operand extremes
		send_cmd(mk(OP_EVAL, 4'hf, '1, '1, '1, '1, '1, '1, 1,
			32'sh7fff_ffff, 32'sh7fff_ffff));
		send_cmd(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000));
		// realistic chain, conflict on the first link
		send_cmd(mk(OP_FIRST, 0, 0, 0, 32'd32768000, 32'h10000, 32'h20000, 32'h10000, 1, 0, 0));
		send_cmd(mk(OP_MIDDLE, 0, 32'h30000, 32'h8000, 32'd6553600, 32'h18000, 32'h10000,
			32'h8000, 0, 0, 0));
		send_cmd(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 32'd13107200, 32'h20000));
		// first link with a negative gain: its slope term is skipped
		send_cmd(mk(OP_FIRST, 0, 0, 0, 32'd32768000, -32'sh10000, 32'h20000, 32'h10000, 0,
			0, 0));
		send_cmd(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 32'd13107200, 32'h20000));

		// random phases; two reach the full chain or a saturated count
		for (p = 0; p < 22; p++)
			run_phase(24, (p == 7 || p == 15));
		drain();

		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d command beats; %0d evaluates, %0d results checked,", items_sent,
			sb.evals, sb.checked);
		$display("%0d with divide fault, %0d with conflict; %0d mismatches.", sb.faults,
			sb.conflicts, sb.mismatches + sb.pending_results.size());
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
